// ----- rtl/mse_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, opcodes and constants for the MIPS subset execute step.
package mse_pkg;

   localparam logic [31:0] VECTOR_RESET = 32'h8000_0080;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_COP0    = 6'h10;

   localparam logic [5:0] FN_SLL     = 6'h00;
   localparam logic [5:0] FN_SRL     = 6'h02;
   localparam logic [5:0] FN_JR      = 6'h08;
   localparam logic [5:0] FN_SYSCALL = 6'h0C;
   localparam logic [5:0] FN_ADD     = 6'h20;
   localparam logic [5:0] FN_SUB     = 6'h22;
   localparam logic [5:0] FN_AND     = 6'h24;
   localparam logic [5:0] FN_OR      = 6'h25;
   localparam logic [5:0] FN_SLT     = 6'h2A;
   localparam logic [5:0] FN_ERET    = 6'h18;

   localparam logic [4:0] RS_MF = 5'h00;
   localparam logic [4:0] RS_MT = 5'h04;
   localparam logic [4:0] RS_CO = 5'h10;

   localparam logic [4:0] COP_STATUS = 5'd12;
   localparam logic [4:0] COP_CAUSE  = 5'd13;
   localparam logic [4:0] COP_EPC    = 5'd14;
   localparam logic [31:0] EXL_MASK  = 32'h0000_0002;

   localparam logic [2:0] EXC_NONE     = 3'd0;
   localparam logic [2:0] EXC_SYSCALL  = 3'd1;
   localparam logic [2:0] EXC_RESERVED = 3'd2;
   localparam logic [2:0] EXC_UNUSABLE = 3'd3;
   localparam logic [2:0] EXC_OVERFLOW = 3'd4;

   localparam logic [4:0] CODE_SYSCALL  = 5'h08;
   localparam logic [4:0] CODE_RESERVED = 5'h0A;
   localparam logic [4:0] CODE_UNUSABLE = 5'h0B;
   localparam logic [4:0] CODE_OVERFLOW = 5'h0C;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [3:0] {
      K_SYSCALL, K_ADD, K_SUB, K_AND, K_OR, K_SLT, K_SLL, K_SRL,
      K_JR, K_MFC0, K_MTC0, K_ERET, K_RESERVED, K_UNUSABLE
   } kind_type;

   // Classified instruction passed from front to back
   typedef struct packed {
      kind_type   kind;
      logic [4:0] rs;
      logic [4:0] rt;
      logic [4:0] rd;
      logic [4:0] shamt;
   } decoded_type;

   typedef struct packed {
      logic [31:0] next_fetch_address;
      logic [2:0]  exception_kind;
      logic        writeback_valid;
      logic [4:0]  writeback_register;
      logic [31:0] writeback_value;
   } result_type;

endpackage

// ----- rtl/mse_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for instruction items and result items.
interface mse_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instruction_word;
   modport source (output valid, output instruction_word, input ready);
   modport sink   (input valid, input instruction_word, output ready);
endinterface

interface mse_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_fetch_address;
   logic [2:0]  exception_kind;
   logic        writeback_valid;
   logic [4:0]  writeback_register;
   logic [31:0] writeback_value;
   modport source (output valid, output next_fetch_address, output exception_kind,
                   output writeback_valid, output writeback_register,
                   output writeback_value, input ready);
   modport sink   (input valid, input next_fetch_address, input exception_kind,
                   input writeback_valid, input writeback_register,
                   input writeback_value, output ready);
endinterface

// ----- rtl/mse_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts instruction items, classifies them and queues them.
module mse_front (
   input  logic               clock,
   input  logic               reset,
   mse_req_if.sink            req,
   output logic               q_valid,
   output mse_pkg::decoded_type q_data,
   input  logic               q_pop
);
   localparam int PW = $clog2(mse_pkg::QUEUE_DEPTH);

   mse_pkg::decoded_type      dec;
   mse_pkg::decoded_type      mem_ff [mse_pkg::QUEUE_DEPTH];
   logic [PW-1:0]             wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]               cnt_ff, cnt_in;
   logic                      push;
   logic [5:0]                opc, fn;

   assign opc = req.instruction_word[31:26];
   assign fn  = req.instruction_word[5:0];

   // Classify the instruction word
   always_comb begin
      dec.rs    = req.instruction_word[25:21];
      dec.rt    = req.instruction_word[20:16];
      dec.rd    = req.instruction_word[15:11];
      dec.shamt = req.instruction_word[10:6];
      dec.kind  = mse_pkg::K_RESERVED;
      if (opc == mse_pkg::OP_SPECIAL) begin
         unique case (fn)
            mse_pkg::FN_SYSCALL: dec.kind = mse_pkg::K_SYSCALL;
            mse_pkg::FN_ADD:     dec.kind = mse_pkg::K_ADD;
            mse_pkg::FN_SUB:     dec.kind = mse_pkg::K_SUB;
            mse_pkg::FN_AND:     dec.kind = mse_pkg::K_AND;
            mse_pkg::FN_OR:      dec.kind = mse_pkg::K_OR;
            mse_pkg::FN_SLT:     dec.kind = mse_pkg::K_SLT;
            mse_pkg::FN_SLL:     dec.kind = mse_pkg::K_SLL;
            mse_pkg::FN_SRL:     dec.kind = mse_pkg::K_SRL;
            mse_pkg::FN_JR:      dec.kind = mse_pkg::K_JR;
            default:             dec.kind = mse_pkg::K_RESERVED;
         endcase
      end else if (opc == mse_pkg::OP_COP0) begin
         unique case (dec.rs)
            mse_pkg::RS_MF: dec.kind = mse_pkg::K_MFC0;
            mse_pkg::RS_MT: dec.kind = mse_pkg::K_MTC0;
            mse_pkg::RS_CO: dec.kind = (fn == mse_pkg::FN_ERET) ? mse_pkg::K_ERET
                                                                 : mse_pkg::K_RESERVED;
            default:        dec.kind = mse_pkg::K_UNUSABLE;
         endcase
      end
   end

   assign req.ready = (cnt_ff != (PW+1)'(mse_pkg::QUEUE_DEPTH));
   assign push      = req.valid & req.ready;
   assign q_valid   = (cnt_ff != '0);
   assign q_data    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push  ? wp_ff + 1'b1 : wp_ff;
      rp_in  = q_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(q_pop);
   end

   // Advance queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= dec;
      end
   end
endmodule

// ----- rtl/mse_back.sv -----
`timescale 1ns / 1ps
// Back end: executes classified items against the register state.
module mse_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [31:0]          vector,
   input  logic                 q_valid,
   input  mse_pkg::decoded_type q_data,
   output logic                 q_pop,
   mse_rsp_if.source            rsp
);
   logic [31:0] gpr_ff [32];
   logic [31:0] cop_ff [32];
   logic [31:0] pc_ff, pc_in, tgt_ff;
   logic        jp_ff;
   logic        rv_ff;
   mse_pkg::result_type res_ff, res;
   logic [31:0] a, b, sum, diff, wv;
   logic        we, exc, ovf, eret, mtc0, jump;
   logic [2:0]  ek;
   logic [4:0]  ecode, wr;

   assign a    = (q_data.rs == 5'd0) ? '0 : gpr_ff[q_data.rs];
   assign b    = (q_data.rt == 5'd0) ? '0 : gpr_ff[q_data.rt];
   assign sum  = a + b;
   assign diff = a - b;
   assign ovf  = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);

   // Execute one item
   always_comb begin
      we = 1'b0; wr = q_data.rd; wv = '0;
      exc = 1'b0; ek = mse_pkg::EXC_NONE; ecode = '0;
      eret = 1'b0; mtc0 = 1'b0; jump = 1'b0;
      unique case (q_data.kind)
         mse_pkg::K_SYSCALL: begin
            exc = 1'b1; ek = mse_pkg::EXC_SYSCALL; ecode = mse_pkg::CODE_SYSCALL;
         end
         mse_pkg::K_ADD: begin
            if (ovf) begin
               exc = 1'b1; ek = mse_pkg::EXC_OVERFLOW; ecode = mse_pkg::CODE_OVERFLOW;
            end else begin
               we = 1'b1; wv = sum;
            end
         end
         mse_pkg::K_SUB: begin we = 1'b1; wv = diff; end
         mse_pkg::K_AND: begin we = 1'b1; wv = a & b; end
         mse_pkg::K_OR:  begin we = 1'b1; wv = a | b; end
         mse_pkg::K_SLT: begin
            we = 1'b1;
            wv = {31'd0, (a[31] ^ b[31]) ? a[31] : diff[31]};
         end
         mse_pkg::K_SLL: begin we = 1'b1; wv = b << q_data.shamt; end
         mse_pkg::K_SRL: begin we = 1'b1; wv = b >> q_data.shamt; end
         mse_pkg::K_JR:  jump = ~jp_ff;
         mse_pkg::K_MFC0: begin we = 1'b1; wr = q_data.rt; wv = cop_ff[q_data.rd]; end
         mse_pkg::K_MTC0: mtc0 = 1'b1;
         mse_pkg::K_ERET: eret = 1'b1;
         mse_pkg::K_RESERVED: begin
            exc = 1'b1; ek = mse_pkg::EXC_RESERVED; ecode = mse_pkg::CODE_RESERVED;
         end
         default: begin
            exc = 1'b1; ek = mse_pkg::EXC_UNUSABLE; ecode = mse_pkg::CODE_UNUSABLE;
         end
      endcase
      if (wr == 5'd0) begin
         we = 1'b0;
      end
      priority if (jp_ff) pc_in = tgt_ff;
      else if (exc)       pc_in = vector;
      else if (eret)      pc_in = cop_ff[mse_pkg::COP_EPC];
      else                pc_in = pc_ff + 32'd4;
      res.next_fetch_address = pc_in;
      res.exception_kind     = ek;
      res.writeback_valid    = we;
      res.writeback_register = we ? wr : 5'd0;
      res.writeback_value    = we ? wv : 32'd0;
   end

   // Output register: take a new item when empty or being drained
   assign q_pop = q_valid & (~rv_ff | rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff  <= 1'b0;
         pc_ff  <= '0;
         jp_ff  <= 1'b0;
         tgt_ff <= '0;
         for (int i = 0; i < 32; i++) begin
            gpr_ff[i] <= '0;
            cop_ff[i] <= '0;
         end
      end else begin
         rv_ff <= q_pop | (rv_ff & ~rsp.ready);
         if (q_pop) begin
            res_ff <= res;
            pc_ff  <= pc_in;
            if (jump) begin
               jp_ff  <= 1'b1;
               tgt_ff <= a;
            end else begin
               jp_ff <= 1'b0;
            end
            if (we) begin
               gpr_ff[wr] <= wv;
            end
            if (mtc0) begin
               cop_ff[q_data.rd] <= b;
            end
            if (exc) begin
               cop_ff[mse_pkg::COP_EPC]    <= pc_ff;
               cop_ff[mse_pkg::COP_CAUSE]  <= {25'd0, ecode, 2'b00};
               cop_ff[mse_pkg::COP_STATUS] <= cop_ff[mse_pkg::COP_STATUS] | mse_pkg::EXL_MASK;
            end
            if (eret) begin
               cop_ff[mse_pkg::COP_STATUS] <= cop_ff[mse_pkg::COP_STATUS] & ~mse_pkg::EXL_MASK;
            end
         end
      end
   end

   assign rsp.valid              = rv_ff;
   assign rsp.next_fetch_address = res_ff.next_fetch_address;
   assign rsp.exception_kind     = res_ff.exception_kind;
   assign rsp.writeback_valid    = res_ff.writeback_valid;
   assign rsp.writeback_register = res_ff.writeback_register;
   assign rsp.writeback_value    = res_ff.writeback_value;
endmodule

// ----- rtl/mips_subset_execute_step_top.sv -----
`timescale 1ns / 1ps
// Top level: front end, item queue, back end and the CSR port.
// An accepted item passes through a queue slot, then the output register, before the result is valid.
// Throughput: one item per cycle while the result side does not stall; execute in the back end is combinational.
// Two-entry queue lets front and back stall independently.
// Reset (synchronous, active high) clears registers, pc, pending jump and sets the vector.
module mips_subset_execute_step_top (
   input  logic        clock,
   input  logic        reset,
   mse_req_if.sink     req,
   mse_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [31:0]          vector_ff;
   logic                 q_valid, q_pop;
   mse_pkg::decoded_type q_data;

   // Hold the exception vector register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? vector_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_ff <= mse_pkg::VECTOR_RESET;
      end else if (csr_psel & csr_penable & csr_pwrite & (csr_paddr == 2'd0)) begin
         vector_ff <= csr_pwdata;
      end
   end

   mse_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
   );

   mse_back u_back (
      .clock(clock), .reset(reset), .vector(vector_ff),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop), .rsp(rsp)
   );
endmodule
